[rtl/prb_pkg.sv]
// Shared field widths, operation codes, count limit and level-search grouping of the priority bitmap run queue.
package prb_pkg;

  // Field widths of the input and result words
  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned TASK_W  = 6;
  localparam int unsigned PRIO_W  = 7;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried in func
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

  // Running count saturates here on a push
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Levels searched per group in the first stage of the level search
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned OFF_W    = 4;

endpackage

[rtl/prb_in_if.sv]
// Input channel: one push or pop request word per handshake.
interface prb_in_if;
  logic                         valid;
  logic                         ready;
  logic [prb_pkg::FUNC_W-1:0]   func;
  logic [prb_pkg::TASK_W-1:0]   task_id;
  logic [prb_pkg::PRIO_W-1:0]   task_prio;

  modport source (output valid, output func, output task_id, output task_prio,
                  input ready);
  modport sink   (input valid, input func, input task_id, input task_prio,
                  output ready);
endinterface

[rtl/prb_out_if.sv]
// Result channel: one result word per request.
interface prb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [prb_pkg::TASK_W-1:0]   out_task;
  logic [prb_pkg::PRIO_W-1:0]   out_prio;
  logic [prb_pkg::COUNT_W-1:0]  running_count;

  modport source (output valid, output found, output out_task, output out_prio,
                  output running_count, input ready);
  modport sink   (input valid, input found, input out_task, input out_prio,
                  input running_count, output ready);
endinterface

[rtl/prb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module prb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/prb_find.sv]
// Two-stage search for the lowest occupied level in the occupancy bitmap.
module prb_find #(
  parameter int unsigned NUM_LEVELS = 128,
  localparam int unsigned LW = $clog2(NUM_LEVELS)
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [NUM_LEVELS-1:0] occ,
  output logic                  hit,
  output logic [LW-1:0]         level
);

  localparam int unsigned GS  = prb_pkg::GRP_SIZE;
  localparam int unsigned OW  = prb_pkg::OFF_W;
  localparam int unsigned NG  = (NUM_LEVELS + GS - 1) / GS;
  localparam int unsigned GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PADW = NG * GS;

  logic [PADW-1:0] occ_pad;
  logic [NG-1:0]   grp_nz;
  logic [OW-1:0]   grp_off [NG];
  logic [NG-1:0]   grp_nz_r;
  logic [OW-1:0]   grp_off_r [NG];
  logic [GW-1:0]   sel;

  assign occ_pad = PADW'(occ);

  // Stage one: lowest set bit inside each group of levels
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nz[g]  = |occ_pad[g*GS +: GS];
      grp_off[g] = '0;
      for (int b = GS - 1; b >= 0; b--) begin
        if (occ_pad[g*GS + b]) begin
          grp_off[g] = OW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_nz_r  <= grp_nz;
      grp_off_r <= grp_off;
    end
  end

  // Stage two: lowest non-empty group
  always_comb begin
    sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_nz_r[g]) begin
        sel = GW'(g);
      end
    end
  end

  assign hit   = |grp_nz_r;
  assign level = LW'({sel, grp_off_r[sel]});

endmodule

[rtl/priority_bitmap_runqueue_core.sv]
// Top level of the priority bitmap run queue: control, bitmap and list memories.
//
// A push appends a task to the FIFO of its priority level; a pop removes the
// head task of the lowest-numbered occupied level. Each level's FIFO is a
// linked list: head and tail per level in one RAM, one next link per task slot
// in a second RAM, and an occupancy bit per level in flip-flops. Every request
// gives exactly one result word. Requests are handled one at a time: a push
// reads the tail of its level, writes the link back and hands off the result;
// a pop selects the lowest occupied level, reads its head and tail, follows
// the next link when the level holds more than one task and hands off the
// result. The registered level search and the registered read data of the
// two RAMs set these steps. A finished result waits in the output register
// while the next request is taken in. No clearing pass is needed after reset.
module priority_bitmap_runqueue_core #(
  parameter int unsigned NUM_LEVELS = 128,
  parameter int unsigned NUM_TASKS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  prb_in_if.sink    in_ch,
  prb_out_if.source out_ch
);

  localparam int unsigned LW = $clog2(NUM_LEVELS);
  localparam int unsigned TW = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_WR,
    S_POP_SEL,
    S_POP_RD,
    S_POP_NX,
    S_RESP
  } state_t;

  state_t                      state_r;
  logic [NUM_LEVELS-1:0]       occ_r;
  logic [prb_pkg::COUNT_W-1:0] count_r;
  logic [LW-1:0]               lvl_r;
  logic [TW-1:0]               id_r;
  logic                        occ_hit_r;
  logic [TW-1:0]               tail_r;

  logic                        res_found_r;
  logic [prb_pkg::TASK_W-1:0]  res_task_r;
  logic [prb_pkg::PRIO_W-1:0]  res_prio_r;

  logic                        out_valid_r;
  logic                        out_found_r;
  logic [prb_pkg::TASK_W-1:0]  out_task_r;
  logic [prb_pkg::PRIO_W-1:0]  out_prio_r;
  logic [prb_pkg::COUNT_W-1:0] out_count_r;

  logic                        in_fire;
  logic                        in_range;
  logic                        is_pop;
  logic                        out_free;

  // Level search
  logic                        fnd_hit;
  logic [LW-1:0]               fnd_level;

  // Head/tail RAM, word is {head, tail}
  logic                        ht_we;
  logic [LW-1:0]               ht_waddr;
  logic [2*TW-1:0]             ht_wdata;
  logic                        ht_re;
  logic [LW-1:0]               ht_raddr;
  logic [2*TW-1:0]             ht_rdata;
  logic [TW-1:0]               ht_head;
  logic [TW-1:0]               ht_tail;

  // Next-link RAM
  logic                        nx_we;
  logic [TW-1:0]               nx_waddr;
  logic [TW-1:0]               nx_wdata;
  logic                        nx_re;
  logic [TW-1:0]               nx_raddr;
  logic [TW-1:0]               nx_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_pop      = (in_ch.func == prb_pkg::FUNC_POP);
  assign in_range    = (32'(in_ch.task_prio) < NUM_LEVELS) &&
                       (32'(in_ch.task_id) < NUM_TASKS);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign ht_head = ht_rdata[2*TW-1:TW];
  assign ht_tail = ht_rdata[TW-1:0];

  prb_find #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_find (
    .clk   (clk),
    .load  (in_fire && is_pop),
    .occ   (occ_r),
    .hit   (fnd_hit),
    .level (fnd_level)
  );

  prb_ram #(
    .WIDTH (2 * TW),
    .DEPTH (NUM_LEVELS)
  ) u_ht_ram (
    .clk   (clk),
    .we    (ht_we),
    .waddr (ht_waddr),
    .wdata (ht_wdata),
    .re    (ht_re),
    .raddr (ht_raddr),
    .rdata (ht_rdata)
  );

  prb_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_TASKS)
  ) u_nx_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (nx_re),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  // Memory access control
  always_comb begin
    ht_we    = 1'b0;
    ht_waddr = lvl_r;
    ht_wdata = {id_r, id_r};
    ht_re    = 1'b0;
    ht_raddr = LW'(in_ch.task_prio);
    nx_we    = 1'b0;
    nx_waddr = ht_tail;
    nx_wdata = id_r;
    nx_re    = 1'b0;
    nx_raddr = ht_head;
    unique case (state_r)
      S_IDLE: begin
        ht_re = in_fire && !is_pop && in_range;
      end
      S_PUSH_WR: begin
        // Occupied level: link behind old tail, keep head
        ht_we = 1'b1;
        nx_we = occ_hit_r;
        if (occ_hit_r) begin
          ht_wdata = {ht_head, id_r};
        end
      end
      S_POP_SEL: begin
        ht_re    = fnd_hit;
        ht_raddr = fnd_level;
      end
      S_POP_RD: begin
        nx_re = (ht_head != ht_tail);
      end
      S_POP_NX: begin
        ht_we    = 1'b1;
        ht_wdata = {nx_rdata, tail_r};
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, bitmap, count and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result word: set on hand-off, dropped when taken
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            lvl_r       <= LW'(in_ch.task_prio);
            id_r        <= TW'(in_ch.task_id);
            occ_hit_r   <= occ_r[LW'(in_ch.task_prio)];
            res_found_r <= 1'b0;
            res_task_r  <= '0;
            res_prio_r  <= '0;
            if (is_pop) begin
              state_r <= S_POP_SEL;
            end else if (in_range) begin
              state_r <= S_PUSH_WR;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_PUSH_WR: begin
          occ_r[lvl_r] <= 1'b1;
          if (count_r != prb_pkg::COUNT_MAX) begin
            count_r <= count_r + prb_pkg::COUNT_W'(1);
          end
          state_r <= S_RESP;
        end
        S_POP_SEL: begin
          lvl_r       <= fnd_level;
          res_found_r <= fnd_hit;
          res_prio_r  <= fnd_hit ? prb_pkg::PRIO_W'(fnd_level) : '0;
          state_r     <= fnd_hit ? S_POP_RD : S_RESP;
        end
        S_POP_RD: begin
          res_task_r <= prb_pkg::TASK_W'(ht_head);
          tail_r     <= ht_tail;
          if (count_r != '0) begin
            count_r <= count_r - prb_pkg::COUNT_W'(1);
          end
          // Last task of the level: the level empties
          if (ht_head == ht_tail) begin
            occ_r[lvl_r] <= 1'b0;
            state_r      <= S_RESP;
          end else begin
            state_r <= S_POP_NX;
          end
        end
        S_POP_NX: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_found_r <= res_found_r;
            out_task_r  <= res_task_r;
            out_prio_r  <= res_prio_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.out_task      = out_task_r;
  assign out_ch.out_prio      = out_prio_r;
  assign out_ch.running_count = out_count_r;

endmodule
